// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AKR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akr assertion failed");

// next-cycle implication, disabled during reset
`define AKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akr assertion failed");

`endif

// ----- rtl/akr_pkg.sv -----
// package: widths, register codes, reset values and the delay shrink function
package akr_pkg;

    localparam int KEY_WIDTH   = 32;
    localparam int KEY_COUNT   = 32;
    localparam int TIME_WIDTH  = 32;
    localparam int DELAY_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 4;

    // mask of keys that exist
    localparam logic [KEY_WIDTH-1:0] KEY_MASK = {KEY_WIDTH{1'b1}} >> (KEY_WIDTH - KEY_COUNT);

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_DELAY  = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DELAY  = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_DELAY = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GROUP_MODE = 4'd3;

    // reset values derived from the tick rate
    localparam int TICKS_PER_SECOND = 840;
    localparam logic [DELAY_WIDTH-1:0] STEP_DELAY_RST = DELAY_WIDTH'(TICKS_PER_SECOND / 12);
    localparam logic [DELAY_WIDTH-1:0] MIN_DELAY_RST  = DELAY_WIDTH'(TICKS_PER_SECOND / 12);
    localparam logic [DELAY_WIDTH-1:0] MAX_DELAY_RST  = DELAY_WIDTH'(TICKS_PER_SECOND >> 1);

    // common control seen by every timer lane
    typedef struct packed {
        logic                   clear;
        logic [DELAY_WIDTH-1:0] reload_delay;
        logic [DELAY_WIDTH-1:0] min_delay;
        logic [DELAY_WIDTH-1:0] step_delay;
        logic [TIME_WIDTH-1:0]  now;
    } akr_ctrl_t;

    // shorten a delay by one step, floored at the minimum
    function automatic logic [DELAY_WIDTH-1:0] shrink_delay(
        input logic [DELAY_WIDTH-1:0] d,
        input logic [DELAY_WIDTH-1:0] dmin,
        input logic [DELAY_WIDTH-1:0] dstep
    );
        logic [DELAY_WIDTH-1:0] r;
        r = d;
        if (d > dmin)
        begin
            if (dstep >= (d - dmin))
                r = dmin;
            else
                r = d - dstep;
        end
        if (r < dmin)
            r = dmin;
        return r;
    endfunction

endpackage

// ----- rtl/akr_intf.sv -----
// channel interfaces: poll words in, pulse words out, configuration writes

interface akr_poll_if;
    logic                           valid;
    logic                           ready;
    logic [akr_pkg::KEY_WIDTH-1:0]  key_states;
    logic [akr_pkg::TIME_WIDTH-1:0] now;

    modport source (output valid, output key_states, output now, input ready);
    modport sink   (input valid, input key_states, input now, output ready);
endinterface

interface akr_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [akr_pkg::KEY_WIDTH-1:0] pulsed_keys;
    logic                          any_held;

    modport source (output valid, output pulsed_keys, output any_held, input ready);
    modport sink   (input valid, input pulsed_keys, input any_held, output ready);
endinterface

interface akr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [akr_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [akr_pkg::DELAY_WIDTH-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/akr_lane.sv -----
// one repeat timer lane: delay and time stamp of one key, or of the whole group
module akr_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  akr_pkg::akr_ctrl_t  ctrl,
    input  logic                en,
    input  logic                key,
    input  logic                key_prev,
    output logic                pulse
);
    import akr_pkg::*;

    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] delay_next;
    logic [TIME_WIDTH-1:0]  last_time_reg;
    logic [TIME_WIDTH-1:0]  last_time_next;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   held;
    logic                   reached;

    // elapsed time against the current delay, modulo the counter width
    always_comb
    begin
        held    = key && key_prev;
        elapsed = ctrl.now - last_time_reg;
        reached = elapsed >= {{(TIME_WIDTH - DELAY_WIDTH){1'b0}}, delay_reg};
        pulse   = held ? reached : key;
    end

    // timer update: reinit on clear, else on an accepted poll
    always_comb
    begin
        delay_next     = delay_reg;
        last_time_next = last_time_reg;
        if (ctrl.clear)
        begin
            delay_next     = ctrl.reload_delay;
            last_time_next = '0;
        end
        else if (en)
        begin
            if (held)
            begin
                if (reached)
                begin
                    delay_next     = shrink_delay(delay_reg, ctrl.min_delay, ctrl.step_delay);
                    last_time_next = ctrl.now;
                end
            end
            else
            begin
                delay_next     = ctrl.reload_delay;
                last_time_next = ctrl.now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= MAX_DELAY_RST;
            last_time_reg <= '0;
        end
        else
        begin
            delay_reg     <= delay_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ----- rtl/accelerating_key_repeat_top.sv -----
// top level: config registers, key timer lanes, group lane and output merge
//
// Use: each word on the poll channel carries the held bit of every key and
// a free-running tick stamp. For each poll word exactly one word leaves on
// the pulse channel: the keys that pulse now (fresh press or accelerated
// repeat) and whether any key is held.
// The pulse word is registered the cycle after poll acceptance. One poll
// word is taken every cycle unless the receiver stalls; all key timers
// work in parallel lanes, each doing one 32-bit elapsed-time subtract and
// compare, and the merge stage selects the per-key or the group result.
// The cfg channel is always ready; a write to any listed register reloads
// every delay with max_delay and zeroes all time stamps and held history.
// Writes are expected only while no poll word is in flight.
// Reset loads min 70, max 420, step 70 ticks, per-key mode, cleared history.
// When the receiver stalls, the pulse word holds in the output register and
// poll ready drops until it is taken; a new poll is taken in the same cycle
// the pending word leaves.
module accelerating_key_repeat_top (
    input logic      clk,
    input logic      rst_n,
    akr_poll_if.sink    poll,
    akr_pulse_if.source pulse,
    akr_cfg_if.sink     cfg
);
    import akr_pkg::*;

    logic [DELAY_WIDTH-1:0] min_delay_reg;
    logic [DELAY_WIDTH-1:0] max_delay_reg;
    logic [DELAY_WIDTH-1:0] step_delay_reg;
    logic                   group_mode_reg;
    logic [KEY_WIDTH-1:0]   prev_keys_reg;
    logic                   prev_any_reg;
    logic                   out_valid_reg;
    logic [KEY_WIDTH-1:0]   out_keys_reg;
    logic                   out_any_reg;

    logic                   cfg_write;
    logic                   cfg_hit;
    logic                   accept;
    logic [KEY_WIDTH-1:0]   keys;
    logic                   any_now;
    logic [KEY_WIDTH-1:0]   lane_pulse;
    logic                   group_pulse;
    logic [KEY_WIDTH-1:0]   pulsed_next;
    akr_ctrl_t              ctrl;

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign cfg_hit   = cfg_write && (cfg.index == REG_MIN_DELAY || cfg.index == REG_MAX_DELAY
                       || cfg.index == REG_STEP_DELAY || cfg.index == REG_GROUP_MODE);
    assign poll.ready = !out_valid_reg || pulse.ready;
    assign accept     = poll.valid && poll.ready;

    // masked key bits of this poll
    assign keys    = poll.key_states & KEY_MASK;
    assign any_now = |keys;

    // lane control word
    always_comb
    begin
        ctrl.clear        = cfg_hit;
        ctrl.reload_delay = (cfg_hit && cfg.index == REG_MAX_DELAY) ? cfg.data : max_delay_reg;
        ctrl.min_delay    = min_delay_reg;
        ctrl.step_delay   = step_delay_reg;
        ctrl.now          = poll.now;
    end

    // per-key timer lanes
    for (genvar k = 0; k < KEY_WIDTH; k++)
    begin : g_lane
        if (k < KEY_COUNT)
        begin : g_used
            akr_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .en       (accept && !group_mode_reg),
                .key      (keys[k]),
                .key_prev (prev_keys_reg[k]),
                .pulse    (lane_pulse[k])
            );
        end
        else
        begin : g_unused
            assign lane_pulse[k] = 1'b0;
        end
    end

    // shared group timer lane
    akr_lane u_group (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .en       (accept && group_mode_reg),
        .key      (any_now),
        .key_prev (prev_any_reg),
        .pulse    (group_pulse)
    );

    // merge lane results
    assign pulsed_next = (group_mode_reg ? (group_pulse ? keys : '0) : lane_pulse) & KEY_MASK;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg  <= MIN_DELAY_RST;
            max_delay_reg  <= MAX_DELAY_RST;
            step_delay_reg <= STEP_DELAY_RST;
            group_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_MIN_DELAY:  min_delay_reg  <= cfg.data;
                REG_MAX_DELAY:  max_delay_reg  <= cfg.data;
                REG_STEP_DELAY: step_delay_reg <= cfg.data;
                REG_GROUP_MODE: group_mode_reg <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // held history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
            prev_any_reg  <= 1'b0;
        end
        else if (cfg_hit)
        begin
            prev_keys_reg <= '0;
            prev_any_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prev_keys_reg <= keys;
            if (group_mode_reg)
                prev_any_reg <= any_now;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (pulse.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_keys_reg <= pulsed_next;
            out_any_reg  <= any_now;
        end
    end

    assign pulse.valid       = out_valid_reg;
    assign pulse.pulsed_keys = out_keys_reg;
    assign pulse.any_held    = out_any_reg;

endmodule

// ----- rtl/akr_checker.sv -----
// port-level checker for the key repeat block, bound to the top level
`include "assert_macros.svh"

module akr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           poll_valid,
    input logic                           poll_ready,
    input logic [akr_pkg::KEY_WIDTH-1:0]  poll_key_states,
    input logic                           pulse_valid,
    input logic                           pulse_ready,
    input logic [akr_pkg::KEY_WIDTH-1:0]  pulse_pulsed_keys,
    input logic                           pulse_any_held
);
    import akr_pkg::*;

    logic                 poll_acc;
    logic [KEY_WIDTH-1:0] poll_held;
    assign poll_acc  = poll_valid && poll_ready;
    assign poll_held = poll_key_states & KEY_MASK;

    // a stalled pulse word stays offered
    `AKR_ASSERT_NEXT(a_out_hold, clk, rst_n, pulse_valid && !pulse_ready, pulse_valid)

    // a full output register that is stalled blocks new polls
    `AKR_ASSERT_NOW(a_block_full, clk, rst_n, pulse_valid && !pulse_ready, !poll_ready)

    // every accepted poll yields a pulse word in the next cycle
    `AKR_ASSERT_NEXT(a_poll_to_pulse, clk, rst_n, poll_acc, pulse_valid)

    // only held keys pulse
    `AKR_ASSERT_NEXT(a_pulse_held, clk, rst_n, poll_acc, ~|(pulse_pulsed_keys & ~$past(poll_held)))

    // any_held follows the masked key bits of the poll
    `AKR_ASSERT_NEXT(a_any_held, clk, rst_n, poll_acc, pulse_any_held == $past(|poll_held))

endmodule

bind accelerating_key_repeat_top akr_checker u_akr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .poll_valid        (poll.valid),
    .poll_ready        (poll.ready),
    .poll_key_states   (poll.key_states),
    .pulse_valid       (pulse.valid),
    .pulse_ready       (pulse.ready),
    .pulse_pulsed_keys (pulse.pulsed_keys),
    .pulse_any_held    (pulse.any_held)
);
